@@ design/pdc_pkg.sv @@
// Shared types, codes and constants of the packet deframer with CRC-32 check.
package pdc_pkg;

    localparam logic [7:0]  SOP_FIRST   = 8'h9A;
    localparam logic [7:0]  SOP_SECOND  = 8'hCC;
    localparam logic [7:0]  TYPE_INVERT = 8'hFF;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;

    localparam int CFG_INDEX_W = 8;

    localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd1000;
    localparam logic [15:0] MAX_PAYLOAD_RESET   = 16'd256;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TIMEOUT_TICKS = 8'd0,
        CFG_MAX_PAYLOAD   = 8'd1
    } cfg_index_t;

    typedef enum logic {
        KIND_BYTE = 1'b0,
        KIND_TICK = 1'b1
    } item_kind_t;

    typedef enum logic [1:0] {
        RES_PAYLOAD = 2'd0,
        RES_GOOD    = 2'd1,
        RES_BAD_CRC = 2'd2,
        RES_ABORT   = 2'd3
    } result_kind_t;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [15:0] max_payload_length;
    } pdc_cfg_t;

endpackage

@@ design/pdc_in_if.sv @@
// Input item channel: received bytes and timer ticks.
interface pdc_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] rx_byte;

    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

@@ design/pdc_out_if.sv @@
// Result item channel: payload bytes and end-of-frame reports.
interface pdc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  frame_type;
    logic [15:0] payload_length;
    logic [15:0] byte_index;
    logic [7:0]  payload_byte;

    modport source (output valid, output result_kind, output frame_type,
                    output payload_length, output byte_index, output payload_byte,
                    input ready);
    modport sink   (input valid, input result_kind, input frame_type,
                    input payload_length, input byte_index, input payload_byte,
                    output ready);
endinterface

@@ design/pdc_cfg_if.sv @@
// Configuration write channel: register index and write data.
interface pdc_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/packet_deframer_crc32_check.sv @@
// Top level of the packet deframer with CRC-32 check.
//
//   channel | direction | carries
//   --------+-----------+----------------------------------------------------
//   rx      | sink      | kind, rx_byte (received byte or one timer tick)
//   res     | source    | result_kind, frame_type, payload_length,
//           |           | byte_index, payload_byte
//   cfg     | sink      | index, data (0 timeout_ticks, 1 max_payload_length)
//
// One transaction per cycle on rx unless a stalled res holds the input register; the
// byte-wide CRC update and the frame state step sit between the input register and
// the result register. A result passes through the input register and then the result register.
// A stalled res holds the result register and then the input register; rx
// keeps accepting while the input register can move on.
// rst_n clears the frame state and loads the register defaults; cfg is always ready.
module packet_deframer_crc32_check
    import pdc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    pdc_in_if.sink    rx,
    pdc_out_if.source res,
    pdc_cfg_if.sink   cfg
);

    pdc_cfg_t cfg_values;

    pdc_cfg_regs u_cfg_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cfg_values (cfg_values)
    );

    pdc_frame_fsm u_frame_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_values (cfg_values),
        .rx         (rx),
        .res        (res)
    );

endmodule

@@ design/pdc_cfg_regs.sv @@
// Configuration registers: timeout in ticks and largest payload length.
module pdc_cfg_regs
    import pdc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    pdc_cfg_if.sink   cfg,
    output pdc_cfg_t  cfg_values
);

    logic [15:0] timeout_ticks_reg;
    logic [15:0] max_payload_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ticks_reg <= TIMEOUT_TICKS_RESET;
            max_payload_reg   <= MAX_PAYLOAD_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg.data;
                CFG_MAX_PAYLOAD:   max_payload_reg   <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_values.timeout_ticks      = timeout_ticks_reg;
    assign cfg_values.max_payload_length = max_payload_reg;

endmodule

@@ design/pdc_crc32_byte.sv @@
// Reflected CRC-32 update by one byte.
module pdc_crc32_byte
    import pdc_pkg::*;
(
    input  logic [31:0] crc_in,
    input  logic [7:0]  data,
    output logic [31:0] crc_out
);

    always_comb
    begin
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        crc_out = c;
    end

endmodule

@@ design/pdc_frame_fsm.sv @@
// Frame state machine: input register, header/payload/CRC parse, result register.
module pdc_frame_fsm
    import pdc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  pdc_cfg_t  cfg_values,
    pdc_in_if.sink    rx,
    pdc_out_if.source res
);

    typedef enum logic [3:0] {
        ST_IDLE      = 4'd0,
        ST_GOT_SOP0  = 4'd1,
        ST_GOT_SOP1  = 4'd2,
        ST_GOT_TYPE  = 4'd3,
        ST_GOT_NTYPE = 4'd4,
        ST_GOT_LEN_HI = 4'd5,
        ST_PAYLOAD   = 4'd6,
        ST_CRC_B1    = 4'd7,
        ST_CRC_B2    = 4'd8,
        ST_CRC_B3    = 4'd9
    } state_t;

    // input stage
    logic        s1_valid_reg;
    logic        s1_kind_reg;
    logic [7:0]  s1_byte_reg;

    // frame state
    state_t      state_reg, state_next;
    logic [7:0]  held_type_reg, held_type_next;
    logic [15:0] held_length_reg, held_length_next;
    logic [15:0] bytes_received_reg, bytes_received_next;
    logic [31:0] received_crc_reg, received_crc_next;
    logic [31:0] running_crc_reg, running_crc_next;
    logic [15:0] ticks_left_reg, ticks_left_next;
    logic        timer_armed_reg, timer_armed_next;

    // result register
    logic         res_valid_reg;
    result_kind_t res_kind_reg;
    logic [7:0]   res_type_reg;
    logic [15:0]  res_length_reg;
    logic [15:0]  res_index_reg;
    logic [7:0]   res_byte_reg;

    logic         advance;
    logic         fire;
    logic         emit;
    result_kind_t emit_kind;
    logic [15:0]  emit_index;
    logic [7:0]   emit_byte;
    logic         frame_start;
    logic [31:0]  crc_seed;
    logic [31:0]  crc_fed;

    assign advance  = !res_valid_reg || res.ready;
    assign fire     = s1_valid_reg && advance;
    assign rx.ready = !s1_valid_reg || advance;

    always_comb
    begin
        case (state_reg)
            ST_GOT_SOP0, ST_GOT_SOP1, ST_GOT_TYPE, ST_GOT_NTYPE, ST_GOT_LEN_HI,
            ST_PAYLOAD, ST_CRC_B1, ST_CRC_B2, ST_CRC_B3: frame_start = 1'b0;
            default: frame_start = 1'b1;
        endcase
    end

    assign crc_seed = frame_start ? CRC_INIT : running_crc_reg;

    pdc_crc32_byte u_crc (
        .crc_in  (crc_seed),
        .data    (s1_byte_reg),
        .crc_out (crc_fed)
    );

    always_comb
    begin
        state_next          = state_reg;
        held_type_next      = held_type_reg;
        held_length_next    = held_length_reg;
        bytes_received_next = bytes_received_reg;
        received_crc_next   = received_crc_reg;
        running_crc_next    = running_crc_reg;
        ticks_left_next     = ticks_left_reg;
        timer_armed_next    = timer_armed_reg;
        emit                = 1'b0;
        emit_kind           = RES_PAYLOAD;
        emit_index          = bytes_received_reg;
        emit_byte           = 8'd0;

        if (fire)
        begin
            if (s1_kind_reg == KIND_TICK)
            begin
                if (timer_armed_reg)
                begin
                    if (ticks_left_reg <= 16'd1)
                    begin
                        state_next       = ST_IDLE;
                        timer_armed_next = 1'b0;
                        ticks_left_next  = 16'd0;
                        emit             = 1'b1;
                        emit_kind        = RES_ABORT;
                    end
                    else
                    begin
                        ticks_left_next = ticks_left_reg - 16'd1;
                    end
                end
            end
            else
            begin
                case (state_reg)
                    ST_GOT_SOP0:
                    begin
                        if (s1_byte_reg == SOP_SECOND)
                        begin
                            running_crc_next = crc_fed;
                            state_next       = ST_GOT_SOP1;
                        end
                        else
                        begin
                            state_next       = ST_IDLE;
                            timer_armed_next = 1'b0;
                            ticks_left_next  = 16'd0;
                        end
                    end
                    ST_GOT_SOP1:
                    begin
                        running_crc_next = crc_fed;
                        held_type_next   = s1_byte_reg;
                        state_next       = ST_GOT_TYPE;
                    end
                    ST_GOT_TYPE:
                    begin
                        if ((s1_byte_reg ^ TYPE_INVERT) == held_type_reg)
                        begin
                            running_crc_next = crc_fed;
                            state_next       = ST_GOT_NTYPE;
                        end
                        else
                        begin
                            state_next       = ST_IDLE;
                            timer_armed_next = 1'b0;
                            ticks_left_next  = 16'd0;
                        end
                    end
                    ST_GOT_NTYPE:
                    begin
                        running_crc_next = crc_fed;
                        held_length_next = {s1_byte_reg, 8'd0};
                        state_next       = ST_GOT_LEN_HI;
                    end
                    ST_GOT_LEN_HI:
                    begin
                        running_crc_next    = crc_fed;
                        held_length_next    = {held_length_reg[15:8], s1_byte_reg};
                        bytes_received_next = 16'd0;
                        if ({held_length_reg[15:8], s1_byte_reg} >
                            cfg_values.max_payload_length)
                        begin
                            state_next       = ST_IDLE;
                            timer_armed_next = 1'b0;
                            ticks_left_next  = 16'd0;
                            emit             = 1'b1;
                            emit_kind        = RES_ABORT;
                            emit_index       = 16'd0;
                        end
                        else
                        begin
                            state_next = ST_PAYLOAD;
                        end
                    end
                    ST_PAYLOAD:
                    begin
                        if (bytes_received_reg < held_length_reg)
                        begin
                            running_crc_next    = crc_fed;
                            bytes_received_next = bytes_received_reg + 16'd1;
                            emit                = 1'b1;
                            emit_kind           = RES_PAYLOAD;
                            emit_byte           = s1_byte_reg;
                        end
                        else
                        begin
                            received_crc_next = {s1_byte_reg, 24'd0};
                            state_next        = ST_CRC_B1;
                        end
                    end
                    ST_CRC_B1:
                    begin
                        received_crc_next = received_crc_reg | {8'd0, s1_byte_reg, 16'd0};
                        state_next        = ST_CRC_B2;
                    end
                    ST_CRC_B2:
                    begin
                        received_crc_next = received_crc_reg | {16'd0, s1_byte_reg, 8'd0};
                        state_next        = ST_CRC_B3;
                    end
                    ST_CRC_B3:
                    begin
                        received_crc_next = received_crc_reg | {24'd0, s1_byte_reg};
                        state_next        = ST_IDLE;
                        timer_armed_next  = 1'b0;
                        ticks_left_next   = 16'd0;
                        emit              = 1'b1;
                        emit_kind         = ((received_crc_reg | {24'd0, s1_byte_reg}) ==
                                             ~running_crc_reg) ? RES_GOOD : RES_BAD_CRC;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                        if (s1_byte_reg == SOP_FIRST)
                        begin
                            held_type_next      = 8'd0;
                            held_length_next    = 16'd0;
                            bytes_received_next = 16'd0;
                            received_crc_next   = 32'd0;
                            running_crc_next    = crc_fed;
                            ticks_left_next     = cfg_values.timeout_ticks;
                            timer_armed_next    = 1'b1;
                            state_next          = ST_GOT_SOP0;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg       <= 1'b0;
            s1_kind_reg        <= KIND_BYTE;
            s1_byte_reg        <= 8'd0;
            state_reg          <= ST_IDLE;
            held_type_reg      <= 8'd0;
            held_length_reg    <= 16'd0;
            bytes_received_reg <= 16'd0;
            received_crc_reg   <= 32'd0;
            running_crc_reg    <= CRC_INIT;
            ticks_left_reg     <= 16'd0;
            timer_armed_reg    <= 1'b0;
            res_valid_reg      <= 1'b0;
            res_kind_reg       <= RES_PAYLOAD;
            res_type_reg       <= 8'd0;
            res_length_reg     <= 16'd0;
            res_index_reg      <= 16'd0;
            res_byte_reg       <= 8'd0;
        end
        else
        begin
            if (rx.ready)
            begin
                s1_valid_reg <= rx.valid;
            end
            if (rx.valid && rx.ready)
            begin
                s1_kind_reg <= rx.kind;
                s1_byte_reg <= rx.rx_byte;
            end

            state_reg          <= state_next;
            held_type_reg      <= held_type_next;
            held_length_reg    <= held_length_next;
            bytes_received_reg <= bytes_received_next;
            received_crc_reg   <= received_crc_next;
            running_crc_reg    <= running_crc_next;
            ticks_left_reg     <= ticks_left_next;
            timer_armed_reg    <= timer_armed_next;

            if (advance)
            begin
                res_valid_reg <= emit;
            end
            if (emit)
            begin
                res_kind_reg   <= emit_kind;
                res_type_reg   <= held_type_next;
                res_length_reg <= held_length_next;
                res_index_reg  <= emit_index;
                res_byte_reg   <= emit_byte;
            end
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.result_kind    = res_kind_reg;
    assign res.frame_type     = res_type_reg;
    assign res.payload_length = res_length_reg;
    assign res.byte_index     = res_index_reg;
    assign res.payload_byte   = res_byte_reg;

    a_idle_timer_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        !timer_armed_reg |-> (ticks_left_reg == 16'd0))
        else $error("timer stopped with ticks left");

    a_frame_has_timer: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> timer_armed_reg)
        else $error("frame in progress without running timer");

    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAYLOAD) |-> (bytes_received_reg <= held_length_reg))
        else $error("payload count beyond header length");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_byte_reg)))
        else $error("input stage lost an item while stalled");

endmodule
